### sv/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types and constants shared by the selective repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int SEQ_BITS  = 3;
	localparam int WORD_BITS = 32;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic [SEQ_BITS-1:0]  seq_num;
		logic                 checksum_ok;
		logic [WORD_BITS-1:0] payload;
	} srr_in_t;

	typedef struct packed {
		logic                 result_kind;
		logic [SEQ_BITS-1:0]  ack_num;
		logic [WORD_BITS-1:0] delivered_payload;
		logic                 last;
	} srr_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK,
		ST_DLV
	} srr_state_t;

endpackage

### sv/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective repeat receiver: stores in-window packets in a slot RAM, acknowledges
// every intact packet and delivers the in-order run from the window base.
// Acknowledgement: registered in the ACK state once the output register is free.
// Requests: a new one is taken only when idle, after its acknowledgement and its
//   run of 0 to SEQ_SPACE/2 deliveries are registered; a corrupted one yields nothing.
// Reset: window base, slot flags and control cleared at once; RAM contents undefined.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
	import srr_pkg::*;
#(
	parameter int SEQ_SPACE    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  srr_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output srr_out_t out_data
);

	localparam int WIN = SEQ_SPACE / 2;
	localparam int SW  = $clog2(SEQ_SPACE);
	localparam int HW  = $clog2(WIN);
	localparam int NW  = ((SW > SEQ_BITS) ? SW : SEQ_BITS) + 1;
	localparam int DW  = (PAYLOAD_BITS < WORD_BITS) ? PAYLOAD_BITS : WORD_BITS;

	srr_state_t state_q, state_d;

	logic [SW-1:0]   base_q;
	logic [HW-1:0]   head_q;
	logic [HW-1:0]   cnt_q;
	logic [WIN-1:0]  filled_q;

	logic [SEQ_BITS-1:0] seq_s1;
	logic                in_win_s1;
	logic [HW-1:0]       phys_s1;
	logic [DW-1:0]       word_s1;

	logic            fwd_q;
	logic [DW-1:0]   fwd_word_q;

	logic            out_valid_q;
	srr_out_t        out_q;

	logic [NW-1:0]   seq_ext, seq_red, off_raw, off;
	logic [HW:0]     phys_sum;
	logic [HW-1:0]   phys;
	logic [HW-1:0]   head_nxt;
	logic [SW-1:0]   base_nxt;
	logic            accept, out_free, ack_go, dlv_go, base_hit, dlv_last;
	logic            rd_en;
	logic [HW-1:0]   rd_addr;
	logic [DW-1:0]   rd_word, dlv_word;

	// window offset of the arriving number
	assign seq_ext  = NW'(in_data.seq_num);
	assign seq_red  = (seq_ext >= NW'(SEQ_SPACE)) ? seq_ext - NW'(SEQ_SPACE) : seq_ext;
	assign off_raw  = seq_red + NW'(SEQ_SPACE) - NW'(base_q);
	assign off      = (off_raw >= NW'(SEQ_SPACE)) ? off_raw - NW'(SEQ_SPACE) : off_raw;
	assign phys_sum = (HW+1)'(head_q) + (HW+1)'(off);
	assign phys     = (phys_sum >= (HW+1)'(WIN)) ? HW'(phys_sum - (HW+1)'(WIN))
	                                             : HW'(phys_sum);

	assign head_nxt = (head_q == HW'(WIN - 1)) ? '0 : head_q + 1'b1;
	assign base_nxt = (base_q == SW'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;

	assign out_free = !out_valid_q || out_ready;
	assign base_hit = filled_q[head_q] || (phys_s1 == head_q);
	assign dlv_last = (cnt_q == HW'(WIN - 1)) || !filled_q[head_nxt];
	assign dlv_word = fwd_q ? fwd_word_q : rd_word;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_data.checksum_ok) begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (out_free) begin
					state_d = (in_win_s1 && base_hit) ? ST_DLV : ST_IDLE;
				end
			end
			ST_DLV: begin
				if (out_free && dlv_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		ack_go   = 1'b0;
		dlv_go   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_ACK: begin
				ack_go  = out_free;
				rd_en   = out_free && in_win_s1 && base_hit;
				rd_addr = head_q;
			end
			ST_DLV: begin
				dlv_go  = out_free;
				rd_en   = out_free && !dlv_last;
				rd_addr = head_nxt;
			end
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			filled_q    <= '0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ack_go) begin
				cnt_q <= '0;
				fwd_q <= in_win_s1 && (phys_s1 == head_q);
				if (in_win_s1) begin
					filled_q[phys_s1] <= 1'b1;
				end
			end
			if (dlv_go) begin
				filled_q[head_q] <= 1'b0;
				head_q           <= head_nxt;
				base_q           <= base_nxt;
				cnt_q            <= cnt_q + 1'b1;
				fwd_q            <= 1'b0;
			end
			if (ack_go || dlv_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_s1    <= SEQ_BITS'(seq_red);
			in_win_s1 <= off < NW'(WIN);
			phys_s1   <= phys;
			word_s1   <= in_data.payload[DW-1:0];
		end
		if (ack_go) begin
			fwd_word_q <= word_s1;
			out_q      <= '{result_kind: KIND_ACK, ack_num: seq_s1,
			                delivered_payload: '0,
			                last: !(in_win_s1 && base_hit)};
		end else if (dlv_go) begin
			out_q      <= '{result_kind: KIND_DATA, ack_num: '0,
			                delivered_payload: WORD_BITS'(dlv_word),
			                last: dlv_last};
		end
	end

	srr_ram #(
		.WIDTH (DW),
		.DEPTH (WIN)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ack_go && in_win_s1),
		.wr_addr (phys_s1),
		.wr_data (word_s1),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_dlv_head_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DLV |-> filled_q[head_q])
		else $error("delivering from an empty slot");

	a_dlv_result: assert property (@(posedge clk) disable iff (!arst_n)
		dlv_go |=> out_valid_q && out_q.result_kind == KIND_DATA)
		else $error("delivery not registered");

	a_slot_marked: assert property (@(posedge clk) disable iff (!arst_n)
		ack_go && in_win_s1 |=> filled_q[$past(phys_s1)])
		else $error("stored slot not marked");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives packets into the selective repeat receiver and scores every result.
// A table of directed requests comes first: corrupted and out-of-window
// packets, duplicates, a full in-order run and window wrap-around. Random
// traffic follows, mostly in-window with some noise. Expected results come
// from a behavioural window tracker. Either side idles in random bursts, and
// the result side holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
	import srr_pkg::*;

	localparam int WIN         = (1 << SEQ_BITS) / 2;
	localparam int IW          = $clog2(WIN);
	localparam int RAND_ITEMS  = 148;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum {ROW_PREDICT, ROW_SILENT, ROW_ACK} row_kind_t;

	typedef struct {
		srr_in_t             pkt;
		row_kind_t           kind;
		logic [SEQ_BITS-1:0] ack;
	} row_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	srr_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	srr_out_t out_data;

	// window tracker
	logic [SEQ_BITS-1:0]  win_base;
	bit                   slot_full [WIN];
	logic [WORD_BITS-1:0] slot_word [WIN];

	srr_out_t pending [$];
	row_t     plan [$];
	int       n_err    = 0;
	int       cycles   = 0;
	bit       calm     = 1'b0;
	bit       squeeze  = 1'b0;
	bit       squeezed = 1'b0;
	int       stall_left = 0;

	selective_repeat_receiver u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	function automatic row_t mk(logic [SEQ_BITS-1:0] s, logic ok, logic [WORD_BITS-1:0] w,
			row_kind_t k, logic [SEQ_BITS-1:0] a);
		row_t r;
		r.pkt.seq_num     = s;
		r.pkt.checksum_ok = ok;
		r.pkt.payload     = w;
		r.kind            = k;
		r.ack             = a;
		return r;
	endfunction

	task automatic track_packet(input srr_in_t pkt, input bit book);
		logic [SEQ_BITS-1:0] offs;
		int run;
		srr_out_t r;
		if (!pkt.checksum_ok)
			return;
		offs = pkt.seq_num - win_base;
		r = '0;
		r.result_kind = KIND_ACK;
		r.ack_num     = pkt.seq_num;
		if (offs >= WIN) begin
			r.last = 1'b1;
			if (book)
				pending.push_back(r);
			return;
		end
		slot_full[offs[IW-1:0]] = 1'b1;
		slot_word[offs[IW-1:0]] = pkt.payload;
		run = 0;
		while (run < WIN && slot_full[run])
			run++;
		r.last = (run == 0);
		if (book)
			pending.push_back(r);
		for (int i = 0; i < run; i++) begin
			r = '0;
			r.result_kind       = KIND_DATA;
			r.delivered_payload = slot_word[i];
			r.last              = (i == run - 1);
			if (book)
				pending.push_back(r);
		end
		if (run > 0) begin
			for (int i = 0; i < WIN; i++) begin
				if (i + run < WIN) begin
					slot_full[i] = slot_full[i + run];
					slot_word[i] = slot_word[i + run];
				end else begin
					slot_full[i] = 1'b0;
					slot_word[i] = '0;
				end
			end
			win_base = win_base + SEQ_BITS'(run);
		end
	endtask

	// request stays valid until the edge at which it is taken
	task automatic offer(input srr_in_t pkt);
		in_valid <= 1'b1;
		in_data  <= pkt;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic sender_gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic flag_mismatch(input bit none_due, input srr_out_t want, input srr_out_t got);
		n_err++;
		if (n_err <= 10) begin
			if (none_due)
				$display("unexpected result: kind %0d ack %0d data %h last %0d",
					got.result_kind, got.ack_num, got.delivered_payload, got.last);
			else
				$display({"mismatch: exp kind %0d ack %0d data %h last %0d,",
					" got kind %0d ack %0d data %h last %0d"},
					want.result_kind, want.ack_num, want.delivered_payload, want.last,
					got.result_kind, got.ack_num, got.delivered_payload, got.last);
		end
	endtask

	// result side: scoring and out_ready pacing
	always @(posedge clk) begin
		srr_out_t want;
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				flag_mismatch(1'b1, '0, out_data);
			end else begin
				want = pending.pop_front();
				if (out_data.result_kind !== want.result_kind ||
						out_data.ack_num !== want.ack_num ||
						out_data.delivered_payload !== want.delivered_payload ||
						out_data.last !== want.last)
					flag_mismatch(1'b0, want, out_data);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (squeeze && !squeezed) begin
			squeezed   = 1'b1;
			stall_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		srr_in_t  pkt;
		srr_out_t fixed;
		int       n_sent;
		int       pick;

		win_base = '0;
		for (int i = 0; i < WIN; i++) begin
			slot_full[i] = 1'b0;
			slot_word[i] = '0;
		end

		plan.push_back(mk(3'd0, 1'b0, 32'hFFFF_FFFF, ROW_SILENT,  3'd0));
		plan.push_back(mk(3'd4, 1'b1, 32'h0000_0000, ROW_ACK,     3'd4));
		plan.push_back(mk(3'd7, 1'b1, 32'hFFFF_FFFF, ROW_ACK,     3'd7));
		plan.push_back(mk(3'd1, 1'b1, 32'h0000_0000, ROW_ACK,     3'd1));
		plan.push_back(mk(3'd1, 1'b1, 32'hFFFF_FFFF, ROW_ACK,     3'd1));
		plan.push_back(mk(3'd3, 1'b1, 32'hA5A5_A5A5, ROW_ACK,     3'd3));
		plan.push_back(mk(3'd2, 1'b1, 32'h5A5A_5A5A, ROW_ACK,     3'd2));
		plan.push_back(mk(3'd0, 1'b1, 32'h1234_5678, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd4, 1'b0, 32'hFFFF_FFFF, ROW_SILENT,  3'd0));
		plan.push_back(mk(3'd0, 1'b1, 32'hDEAD_BEEF, ROW_ACK,     3'd0));
		plan.push_back(mk(3'd3, 1'b1, 32'h0F0F_0F0F, ROW_ACK,     3'd3));
		plan.push_back(mk(3'd4, 1'b1, 32'h0000_0001, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd7, 1'b1, 32'hFFFF_FFFE, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd5, 1'b1, 32'h8000_0000, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd6, 1'b1, 32'h7FFF_FFFF, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd3, 1'b1, 32'h1111_1111, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd3, 1'b1, 32'h2222_2222, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd0, 1'b1, 32'h3333_3333, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd1, 1'b0, 32'h0000_0000, ROW_SILENT,  3'd0));
		plan.push_back(mk(3'd1, 1'b1, 32'h4444_4444, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd2, 1'b1, 32'h5555_5555, ROW_PREDICT, 3'd0));
		plan.push_back(mk(3'd2, 1'b1, 32'h6666_6666, ROW_ACK,     3'd2));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer(plan[i].pkt);
			track_packet(plan[i].pkt, plan[i].kind == ROW_PREDICT);
			if (plan[i].kind == ROW_ACK) begin
				fixed = '0;
				fixed.result_kind = KIND_ACK;
				fixed.ack_num     = plan[i].ack;
				fixed.last        = 1'b1;
				pending.push_back(fixed);
			end
			sender_gap();
		end

		n_sent = 0;
		while (n_sent < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			pkt.payload = $urandom;
			case ($urandom_range(0, 15))
				0:       pkt.payload = '0;
				1:       pkt.payload = '1;
				default: ;
			endcase
			if (pick < 10) begin
				pkt.checksum_ok = 1'b0;
				pkt.seq_num     = SEQ_BITS'($urandom_range(0, 7));
			end else if (pick < 25) begin
				pkt.checksum_ok = 1'b1;
				pkt.seq_num     = win_base + 3'($urandom_range(WIN, 2 * WIN - 1));
			end else begin
				pkt.checksum_ok = 1'b1;
				pkt.seq_num     = win_base + 3'($urandom_range(0, WIN - 1));
			end
			offer(pkt);
			track_packet(pkt, 1'b1);
			n_sent++;
			if (n_sent == 30)
				squeeze = 1'b1;
			if (n_sent >= 120)
				calm = 1'b1;
			sender_gap();
		end
		in_valid <= 1'b0;
		calm = 1'b1;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (n_err == 0 && pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
